// ===== hdl/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types and constants of the postfix evaluator
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int NUM_VARS = 26;
    localparam logic [4:0] NO_LETTER = 5'd31;

    localparam logic [7:0] TK_LETTER_A = 8'd65;
    localparam logic [7:0] TK_LETTER_Z = 8'd90;
    localparam logic [7:0] TK_DIGIT_0  = 8'd48;
    localparam logic [7:0] TK_DIGIT_9  = 8'd57;
    localparam logic [7:0] TK_PLUS     = 8'h2B;
    localparam logic [7:0] TK_MINUS    = 8'h2D;
    localparam logic [7:0] TK_STAR     = 8'h2A;
    localparam logic [7:0] TK_SLASH    = 8'h2F;
    localparam logic [7:0] TK_PERCENT  = 8'h25;
    localparam logic [7:0] TK_EQUAL    = 8'h3D;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_TOKEN = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNBAL = 2'd1,
        ST_DIV0  = 2'd2,
        ST_FAULT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

endpackage

// ===== hdl/pfe_divider.sv =====
// ----------------------------------------------------------------------------
// pfe_divider
// iterative signed divider, one quotient bit per cycle, c truncation
// ----------------------------------------------------------------------------
module pfe_divider
    import pfe_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [VALUE_WIDTH-1:0] o_remainder
);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_quo, r_rem, r_den;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy, r_done, r_negq, r_negr;
    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH-1:0] w_shift;

    assign w_shift = {r_rem[VALUE_WIDTH-2:0], r_quo[VALUE_WIDTH-1]};
    assign w_trial = {r_rem, r_quo[VALUE_WIDTH-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_WIDTH);
                r_quo  <= i_dividend[VALUE_WIDTH-1] ? -i_dividend : i_dividend;
                r_den  <= i_divisor[VALUE_WIDTH-1] ? -i_divisor : i_divisor;
                r_rem  <= '0;
                r_negq <= i_dividend[VALUE_WIDTH-1] ^ i_divisor[VALUE_WIDTH-1];
                r_negr <= i_dividend[VALUE_WIDTH-1];
            end else if (r_busy) begin
                if (!w_trial[VALUE_WIDTH]) begin
                    r_rem <= w_trial[VALUE_WIDTH-1:0];
                    r_quo <= {r_quo[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[VALUE_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_negq ? -r_quo : r_quo;
    assign o_remainder = r_negr ? -r_rem : r_rem;
endmodule

// ===== hdl/postfix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// postfix evaluator over a tagged value stack with a 26-entry variable table
// ----------------------------------------------------------------------------
// One word is taken at a time. A set word writes its variable at the accepting
// edge. A token word holds o_stall high while it runs: a letter or digit push
// passes accept, stack read and write back; an arithmetic, assignment or
// divide-by-zero token passes accept, read of the second stack entry, execute
// and write back; a bad token, an underflow or a token after a sticky error
// passes accept, read and write back; and / or % add a divide step, run by the
// one-bit-per-cycle divider, between execute and write back.
// The last token's result is loaded into the output register in its write-back
// cycle; a later last token waits in write-back until the previous result has
// been taken. Stack entries live in a synchronous memory with registered read;
// the top entry is also held in registers, so only the second entry is ever
// read from the memory.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [4:0]          i_var_index,
    input  logic signed [31:0]  i_var_value,
    input  logic [7:0]          i_token,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_result,
    output logic [1:0]          o_status
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int EW = VALUE_WIDTH + 5;

    // stack memory entry: tag, value
    logic [EW-1:0] r_stk [STACK_DEPTH];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] w_raddr;
    logic          w_mem_we;

    // variable table, small, read at one place
    logic [VALUE_WIDTH-1:0] r_var [NUM_VARS];

    t_state r_state, n_state;
    logic [DW-1:0] r_depth;
    t_status       r_err;
    logic [7:0]    r_tok;
    logic          r_last;
    // top of stack kept in registers
    logic [VALUE_WIDTH-1:0] r_top;
    logic          r_top_lit;
    // entry to push in the write-back cycle
    logic [VALUE_WIDTH-1:0] r_push_v;
    logic [4:0]    r_push_tag;
    logic          r_push_lit;
    logic          r_push_en;
    // output register
    logic          r_out_v;
    logic [31:0]   r_out_res;
    t_status       r_out_st;

    logic w_acc, w_letter, w_digit, w_arith, w_div_op;
    logic [VALUE_WIDTH-1:0] w_ext, w_second;
    logic [4:0] w_lidx, w_second_tag;
    logic w_asg_ok, w_push_ok, w_push_ovf, w_fin_go;
    t_status w_fin_err;
    logic [DW-1:0] w_fin_depth;
    logic w_dstart, w_ddone;
    logic [VALUE_WIDTH-1:0] w_q, w_r;

    assign w_acc = i_valid && !o_stall;
    assign w_ext = VALUE_WIDTH'(i_var_value);  // sign-extends or truncates

    assign w_letter = r_tok inside {[TK_LETTER_A:TK_LETTER_Z]};
    assign w_digit  = r_tok inside {[TK_DIGIT_0:TK_DIGIT_9]};
    assign w_arith  = r_tok inside {TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH,
                                     TK_PERCENT, TK_EQUAL};
    assign w_div_op = r_tok inside {TK_SLASH, TK_PERCENT};
    assign w_lidx   = 5'(r_tok - TK_LETTER_A);

    // second entry from the stack memory
    assign w_second     = r_rd[VALUE_WIDTH-1:0];
    assign w_second_tag = r_rd[EW-1:VALUE_WIDTH];
    assign w_asg_ok     = r_top_lit && (w_second_tag < 5'(NUM_VARS));

    // write-back helpers
    assign w_push_ok   = r_push_en && (r_depth < DW'(STACK_DEPTH));
    assign w_push_ovf  = r_push_en && (r_depth >= DW'(STACK_DEPTH));
    assign w_fin_go    = !r_last || !r_out_v || !i_stall;
    assign w_fin_err   = (r_err != ST_OK) ? r_err : (w_push_ovf ? ST_FAULT : ST_OK);
    assign w_fin_depth = w_push_ok ? r_depth + DW'(1) : r_depth;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_acc && i_op == OP_TOKEN) n_state = S_READ;
            S_READ: begin
                // only a valid operator over two entries needs the execute step
                if (r_err == ST_OK && w_arith && r_depth >= DW'(2))
                    n_state = S_EXEC;
                else
                    n_state = S_FIN;
            end
            S_EXEC: begin
                if (w_div_op && r_top != '0) n_state = S_DIV;
                else                         n_state = S_FIN;
            end
            S_DIV:  if (w_ddone) n_state = S_FIN;
            // a last token waits here while the previous result is unread
            S_FIN:  if (w_fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_stall  = (r_state != S_IDLE);
        w_dstart = (r_state == S_EXEC) && w_div_op && (r_top != '0);
        w_mem_we = (r_state == S_FIN) && w_fin_go && w_push_ok;
    end

    pfe_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_dividend(w_second), .i_divisor(r_top), .o_done(w_ddone),
        .o_quotient(w_q), .o_remainder(w_r)
    );

    // stack memory: read address is depth-2 (second entry), push at depth
    assign w_raddr = AW'(r_depth - DW'(2));

    always_ff @(posedge i_clk) begin
        r_rd <= r_stk[w_raddr];
        if (w_mem_we)
            r_stk[AW'(r_depth)] <= {r_push_tag, r_push_v};
    end

    // main datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_err     <= ST_OK;
            r_out_v   <= 1'b0;
            r_out_res <= '0;
            r_out_st  <= ST_OK;
            r_push_en <= 1'b0;
            for (int i = 0; i < NUM_VARS; i++) r_var[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && w_fin_go && r_last)
                r_out_v <= 1'b1;
            else if (!i_stall)
                r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_op == OP_TOKEN) begin
                            r_tok  <= i_token;
                            r_last <= i_last;
                        end else if (i_var_index < 5'(NUM_VARS)) begin
                            r_var[i_var_index] <= w_ext;
                        end
                    end
                end
                S_READ: begin
                    if (r_err == ST_OK && w_letter) begin
                        r_push_v   <= r_var[w_lidx];
                        r_push_tag <= w_lidx;
                        r_push_lit <= 1'b0;
                        r_push_en  <= 1'b1;
                    end else if (r_err == ST_OK && w_digit) begin
                        r_push_v   <= VALUE_WIDTH'(r_tok - TK_DIGIT_0);
                        r_push_tag <= NO_LETTER;
                        r_push_lit <= 1'b1;
                        r_push_en  <= 1'b1;
                    end else begin
                        r_push_tag <= NO_LETTER;
                        r_push_lit <= 1'b0;
                        r_push_en  <= 1'b0;
                        // bad token or too few entries for an operator
                        if (r_err == ST_OK && (!w_arith || r_depth < DW'(2)))
                            r_err <= ST_FAULT;
                    end
                end
                S_EXEC: begin
                    case (r_tok)
                        TK_PLUS: begin
                            r_push_v  <= w_second + r_top;
                            r_push_en <= 1'b1;
                            r_depth   <= r_depth - DW'(2);
                        end
                        TK_MINUS: begin
                            r_push_v  <= w_second - r_top;
                            r_push_en <= 1'b1;
                            r_depth   <= r_depth - DW'(2);
                        end
                        TK_STAR: begin
                            r_push_v  <= w_second * r_top;
                            r_push_en <= 1'b1;
                            r_depth   <= r_depth - DW'(2);
                        end
                        TK_EQUAL: begin
                            // top must be a digit literal, second a letter
                            if (w_asg_ok) begin
                                r_var[w_second_tag] <= r_top;
                                r_push_v  <= r_top;
                                r_push_en <= 1'b1;
                                r_depth   <= r_depth - DW'(2);
                            end else begin
                                r_err <= ST_FAULT;
                            end
                        end
                        TK_SLASH, TK_PERCENT: begin
                            if (r_top != '0) begin
                                r_push_en <= 1'b1;
                                r_depth   <= r_depth - DW'(2);
                            end else begin
                                r_err <= ST_DIV0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (w_ddone)
                        r_push_v <= (r_tok == TK_SLASH) ? w_q : w_r;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        if (r_last) begin
                            if (w_fin_err != ST_OK) begin
                                r_out_st  <= w_fin_err;
                                r_out_res <= '0;
                            end else if (w_fin_depth != DW'(1)) begin
                                r_out_st  <= ST_UNBAL;
                                r_out_res <= '0;
                            end else begin
                                // single entry left: it is the top
                                r_out_st  <= ST_OK;
                                r_out_res <= 32'(w_push_ok ? r_push_v : r_top);
                            end
                            r_depth <= '0;
                            r_err   <= ST_OK;
                        end else if (w_push_ok) begin
                            r_depth   <= w_fin_depth;
                            r_top     <= r_push_v;
                            r_top_lit <= r_push_lit;
                        end else if (w_push_ovf) begin
                            r_err <= ST_FAULT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out_res;
    assign o_status = r_out_st;
endmodule

// ===== sim/postfix_expression_evaluator_core_test.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core_test
// self-checking bench: directed and random postfix expressions against a model
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core_test
    import pfe_pkg::*;
();

    localparam int DEPTH = 64;

    // expected result word of one finished expression
    typedef struct {
        logic signed [31:0] value;
        t_status            status;
    } t_outcome;

    // evaluator state mirror and queue of pending outcomes
    class eval_scoreboard;
        logic [31:0] vals [DEPTH];
        logic [4:0]  tags [DEPTH];
        bit          lits [DEPTH];
        int          depth;
        logic [31:0] vars [NUM_VARS];
        t_status     err;
        t_outcome    pending [$];
        int          fails;

        function new();
            depth = 0;
            err = ST_OK;
            fails = 0;
            foreach (vars[i]) vars[i] = '0;
        endfunction

        function void flag(t_status code);
            if (err == ST_OK) err = code;
        endfunction

        function void push(logic [31:0] v, logic [4:0] tg, bit lt);
            if (depth >= DEPTH) begin
                flag(ST_FAULT);
                return;
            end
            vals[depth] = v;
            tags[depth] = tg;
            lits[depth] = lt;
            depth++;
        endfunction

        function void apply_operator(logic [7:0] tk);
            logic [31:0] a, b, r;
            if (depth < 2) begin
                flag(ST_FAULT);
                return;
            end
            b = vals[depth-1];
            a = vals[depth-2];
            if (tk == TK_EQUAL) begin
                if (!lits[depth-1] || tags[depth-2] >= NUM_VARS) begin
                    flag(ST_FAULT);
                    return;
                end
                vars[tags[depth-2]] = b;
                depth -= 2;
                push(b, NO_LETTER, 0);
                return;
            end
            case (tk)
                TK_PLUS:  r = a + b;
                TK_MINUS: r = a - b;
                TK_STAR:  r = a * b;
                default: begin
                    if (b == 0) begin
                        flag(ST_DIV0);
                        return;
                    end
                    // -1 divisor: wrap quotient, zero remainder
                    if (b == 32'hFFFF_FFFF) r = (tk == TK_SLASH) ? -a : '0;
                    else if (tk == TK_SLASH) r = $signed(a) / $signed(b);
                    else r = $signed(a) % $signed(b);
                end
            endcase
            depth -= 2;
            push(r, NO_LETTER, 0);
        endfunction

        // note one accepted input word
        function void note_word(bit op, logic [4:0] idx, logic [31:0] v,
                                logic [7:0] tk, bit lst);
            t_outcome o;
            if (op == OP_SET) begin
                if (idx < NUM_VARS) vars[idx] = v;
                return;
            end
            if (err == ST_OK) begin
                if (tk >= TK_LETTER_A && tk < TK_LETTER_A + NUM_VARS)
                    push(vars[tk - TK_LETTER_A], 5'(tk - TK_LETTER_A), 0);
                else if (tk >= TK_DIGIT_0 && tk <= TK_DIGIT_0 + 9)
                    push(32'(tk - TK_DIGIT_0), NO_LETTER, 1);
                else if (tk == TK_PLUS || tk == TK_MINUS || tk == TK_STAR ||
                         tk == TK_SLASH || tk == TK_PERCENT || tk == TK_EQUAL)
                    apply_operator(tk);
                else
                    flag(ST_FAULT);
            end
            if (!lst) return;
            o.status = err;
            if (o.status == ST_OK && depth != 1) o.status = ST_UNBAL;
            o.value = (o.status == ST_OK) ? vals[0] : '0;
            pending.push_back(o);
            depth = 0;
            err = ST_OK;
        endfunction

        // compare one accepted result word with the oldest outcome
        function void check_result(logic signed [31:0] v, logic [1:0] st);
            t_outcome o;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %0d status %0d", $time, v, st);
                fails++;
                return;
            end
            o = pending.pop_front();
            if (st !== o.status) begin
                $display("%0t: status expected %0d actual %0d", $time, o.status, st);
                fails++;
            end
            if (v !== o.value) begin
                $display("%0t: result expected %0d actual %0d", $time, o.value, v);
                fails++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_op;
    logic [4:0]         i_var_index;
    logic signed [31:0] i_var_value;
    logic [7:0]         i_token;
    logic               i_last;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_result;
    logic [1:0]         o_status;

    eval_scoreboard board;
    longint cycles;
    int     words_sent;
    bit     hold_off;      // long receiver stretch requested by the sender
    int     long_stall_left;

    postfix_expression_evaluator_core uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit: the bench reports failure once the cycle limit is passed
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 600000) begin
                $display("** postfix_expression_evaluator_core: FAILED **");
                $finish;
            end
        end
    end

    // send one word, holding it until accepted, after a random gap
    task automatic send_word(bit op, logic [4:0] idx, logic [31:0] v,
                             logic [7:0] tk, bit lst);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_var_index <= idx;
        i_var_value <= v;
        i_token     <= tk;
        i_last      <= lst;
        do @(posedge i_clk); while (o_stall);
        board.note_word(op, idx, v, tk, lst);
        words_sent++;
    endtask

    task automatic set_var(logic [4:0] idx, logic [31:0] v);
        send_word(OP_SET, idx, v, 8'($urandom), 1'($urandom));
    endtask

    task automatic tok(logic [7:0] tk, bit lst = 0);
        send_word(OP_TOKEN, 5'($urandom), $urandom, tk, lst);
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 4))
            0: return TK_PLUS;
            1: return TK_MINUS;
            2: return TK_STAR;
            3: return TK_SLASH;
            default: return TK_PERCENT;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        return TK_LETTER_A + 8'($urandom_range(0, NUM_VARS - 1));
    endfunction

    function automatic logic [7:0] pick_digit();
        return TK_DIGIT_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(0, 20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    // well-formed expression: random operand tree over letters and digits
    task automatic random_expression();
        int n_operands, stacked, i;
        n_operands = $urandom_range(1, 6);
        stacked = 0;
        i = 0;
        while (i < n_operands || stacked > 1) begin
            if (i < n_operands && (stacked < 2 || $urandom_range(0, 1))) begin
                tok($urandom_range(0, 1) ? pick_letter() : pick_digit(),
                    i == n_operands - 1 && stacked == 0);
                stacked++;
                i++;
            end else begin
                stacked--;
                tok(pick_operator(), i == n_operands && stacked == 1);
            end
        end
    endtask

    // assignment expression: letter digit = [operand op]
    task automatic assign_expression();
        bit more;
        more = $urandom_range(0, 1);
        tok(pick_letter());
        tok(pick_digit());
        tok(TK_EQUAL, !more);
        if (more) begin
            tok(pick_letter());
            tok(pick_operator(), 1);
        end
    endtask

    // noise: any token at all, random last
    task automatic noise_expression();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) tok(8'($urandom), k == n - 1);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int wait_n;
        i_stall = 1'b1;
        long_stall_left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off && long_stall_left == 0) long_stall_left = 400;
            if (long_stall_left > 0) begin
                i_stall <= 1'b1;
                long_stall_left--;
                if (long_stall_left == 0) hold_off = 0;
                @(posedge i_clk);
            end else begin
                wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
                if (wait_n > 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_n) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                do @(posedge i_clk); while (!o_valid);
                board.check_result(o_result, o_status);
            end
        end
    end

    initial begin
        board = new();
        hold_off = 0;
        words_sent = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_op = OP_SET;
        i_var_index = '0;
        i_var_value = '0;
        i_token = '0;
        i_last = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of the table and arithmetic corner cases
        set_var(0, 32'h8000_0000);
        set_var(1, 32'hFFFF_FFFF);
        set_var(25, 32'h7FFF_FFFF);
        set_var(31, 32'h1234_5678);              // out of range index, ignored
        tok("A"); tok("B"); tok(TK_SLASH, 1);     // most negative over -1
        tok("A"); tok("B"); tok(TK_PERCENT, 1);
        tok("Z"); tok("0"); tok(TK_SLASH, 1);     // divide by zero
        tok("9"); tok("Z"); tok(TK_STAR); tok("Z"); tok(TK_MINUS);
        tok("A"); tok(TK_PLUS, 1);
        tok("C"); tok("7"); tok(TK_EQUAL); tok("C"); tok(TK_PLUS, 1);
        tok("3"); tok("4"); tok(TK_EQUAL, 1);     // bad assignment target
        tok("C"); tok("D"); tok(TK_EQUAL, 1);     // right side not a literal
        tok(TK_PLUS); tok("1", 1);                // underflow stays sticky
        tok("a", 1);                              // lower-case letter
        tok("1"); tok("2", 1);                    // unbalanced
        tok(8'hFF, 1);
        tok("5"); set_var(2, 32'd11); tok("C"); tok(TK_MINUS, 1);

        // overflow: one push past the full stack
        for (int k = 0; k <= DEPTH; k++) tok("8", k == DEPTH);
        for (int k = 0; k < DEPTH; k++) tok("6");
        for (int k = 1; k < DEPTH; k++) tok(TK_PLUS, k == DEPTH - 1);

        // random part; long receiver hold-off once, early on
        while (words_sent < 1500) begin
            if (words_sent > 400 && words_sent < 420) hold_off = 1;
            case ($urandom_range(0, 9))
                0, 1:       set_var(5'($urandom_range(0, 31)), pick_value());
                2, 3:       assign_expression();
                4:          noise_expression();
                default:    random_expression();
            endcase
        end
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.fails == 0 && board.pending.size() == 0 && !o_valid)
            $display("** postfix_expression_evaluator_core: PASSED **");
        else
            $display("** postfix_expression_evaluator_core: FAILED **");
        $finish;
    end

endmodule
